### rtl/core/cwc_pkg.sv
`timescale 1ns / 1ps

package cwc_pkg;

   // Field widths fixed by the event and result formats.
   localparam int unsigned CWND_W   = 10;
   localparam int unsigned THR_W    = 9;
   localparam int unsigned CNT_W    = 10;
   localparam int unsigned SIZE_W   = 9;
   localparam int unsigned FLIGHT_W = 9;

   localparam logic [CWND_W-1:0] RESET_CWND         = CWND_W'(1);
   localparam logic [SIZE_W-1:0] RESET_SEND_WINDOW  = SIZE_W'(64);
   localparam logic [THR_W-1:0]  MIN_LOSS_THRESHOLD = THR_W'(2);

   typedef enum logic [1:0] {
      FUNC_ACK             = 2'd0,
      FUNC_FAST_RETRANSMIT = 2'd1,
      FUNC_TIMEOUT         = 2'd2,
      FUNC_INIT            = 2'd3
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [FLIGHT_W-1:0]   flight_count;
   } req_type;

   typedef struct packed {
      logic [CWND_W-1:0]     cwnd_out;
      logic [THR_W-1:0]      threshold_out;
      logic                  slow_start;
   } rsp_type;

   typedef struct packed {
      logic [CWND_W-1:0]     cong_window;
      logic [THR_W-1:0]      threshold;
      logic [CNT_W-1:0]      round_trip_acks;
   } state_type;

endpackage

### rtl/core/cwc_update.sv
`timescale 1ns / 1ps

// Next-state and result logic for one event.
module cwc_update #(
   parameter int unsigned MAX_WINDOW = 256
) (
   input  cwc_pkg::state_type              state,
   input  logic [cwc_pkg::SIZE_W-1:0]      send_window_size,
   input  cwc_pkg::req_type                req,
   output cwc_pkg::state_type              state_next,
   output cwc_pkg::rsp_type                rsp
);

   logic [cwc_pkg::SIZE_W-1:0]   eff_size;
   logic [cwc_pkg::FLIGHT_W-1:0] flight_capped;
   logic [cwc_pkg::THR_W-1:0]    loss_thr;
   logic                         can_grow;
   logic [cwc_pkg::CWND_W-1:0]   cwnd_grown;
   logic [cwc_pkg::CNT_W-1:0]    acks_inc;

   // Size is limited to the largest window this instance supports.
   assign eff_size = (32'(send_window_size) > MAX_WINDOW) ?
                     cwc_pkg::SIZE_W'(MAX_WINDOW) : send_window_size;

   assign flight_capped = (req.flight_count > eff_size) ? eff_size : req.flight_count;
   assign loss_thr = ((flight_capped >> 1) > cwc_pkg::MIN_LOSS_THRESHOLD) ?
                     (flight_capped >> 1) : cwc_pkg::MIN_LOSS_THRESHOLD;

   // The window grows only while half of it is below the effective size.
   assign can_grow   = state.cong_window[cwc_pkg::CWND_W-1:1] < eff_size;
   assign cwnd_grown = can_grow ? state.cong_window + cwc_pkg::CWND_W'(1)
                                : state.cong_window;
   assign acks_inc   = state.round_trip_acks + cwc_pkg::CNT_W'(1);

   always_comb begin
      state_next = state;
      case (req.func)
         cwc_pkg::FUNC_ACK: begin
            if (state.cong_window < {1'b0, state.threshold}) begin
               state_next.cong_window = cwnd_grown;
            end else if (acks_inc >= state.cong_window) begin
               state_next.cong_window     = cwnd_grown;
               state_next.round_trip_acks = '0;
            end else begin
               state_next.round_trip_acks = acks_inc;
            end
         end
         cwc_pkg::FUNC_FAST_RETRANSMIT: begin
            state_next.threshold   = loss_thr;
            state_next.cong_window = {1'b0, loss_thr};
         end
         cwc_pkg::FUNC_TIMEOUT: begin
            state_next.threshold   = loss_thr;
            state_next.cong_window = cwc_pkg::RESET_CWND;
         end
         cwc_pkg::FUNC_INIT: begin
            state_next.cong_window     = cwc_pkg::RESET_CWND;
            state_next.threshold       = eff_size;
            state_next.round_trip_acks = '0;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   assign rsp.cwnd_out      = state_next.cong_window;
   assign rsp.threshold_out = state_next.threshold;
   assign rsp.slow_start    = state_next.cong_window < {1'b0, state_next.threshold};

endmodule

### rtl/core/congestion_window_controller.sv
`timescale 1ns / 1ps

// Channel   Ports                               Direction  Beat
// req       req_valid, req_stall, req_data      in         one event (func, flight_count)
// rsp       rsp_valid, rsp_stall, rsp_data      out        window, threshold, phase
// csr       csr_valid, csr_ready, csr_wdata     in         send window size
//
// One event is accepted per cycle while req_stall is low; its result is registered.
// The window state updates in the same cycle the event is accepted, so events
// chain back to back with no bubble; the update logic is a few compares and adds.
// A two-entry output buffer (result register plus skid) lets an event enter while
// a finished result is still held; req_stall rises only when both entries are full.
// Reset (synchronous) sets the window to 1, threshold and window size to 64 and
// clears the acknowledgement counter. csr_ready is always high.
module congestion_window_controller #(
   parameter int unsigned MAX_WINDOW = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cwc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cwc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cwc_pkg::SIZE_W-1:0]    csr_wdata
);

   // Controller state and the configured send window size.
   cwc_pkg::state_type           state_ff, state_in;
   logic [cwc_pkg::SIZE_W-1:0]   send_window_size_ff, send_window_size_in;

   // Output buffer: the main result register and the skid entry behind it.
   logic                         rsp_valid_ff, rsp_valid_in;
   cwc_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         skid_valid_ff, skid_valid_in;
   cwc_pkg::rsp_type             skid_data_ff, skid_data_in;

   cwc_pkg::state_type           state_next;
   cwc_pkg::rsp_type             result;
   logic                         req_fire;
   logic                         rsp_fire;
   logic                         csr_fire;

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign req_fire = req_valid && !skid_valid_ff;
   assign rsp_fire = rsp_valid_ff && !rsp_stall;
   assign csr_fire = csr_valid && csr_ready;

   cwc_update #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_update (
      .state            (state_ff),
      .send_window_size (send_window_size_ff),
      .req              (req_data),
      .state_next       (state_next),
      .rsp              (result)
   );

   // The state advances only on an accepted event; configuration must be written
   // by the user only while the block is idle, which the block does not enforce.
   always_comb begin
      state_in            = req_fire ? state_next : state_ff;
      send_window_size_in = csr_fire ? csr_wdata : send_window_size_ff;
   end

   // Output buffer control. A draining result register pulls the skid entry
   // forward. A new result goes to the result register when that register is
   // free or being drained this cycle, and to the skid entry otherwise.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_fire) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cong_window     <= cwc_pkg::RESET_CWND;
         state_ff.threshold       <= cwc_pkg::RESET_SEND_WINDOW;
         state_ff.round_trip_acks <= '0;
         send_window_size_ff      <= cwc_pkg::RESET_SEND_WINDOW;
         rsp_valid_ff             <= 1'b0;
         skid_valid_ff            <= 1'b0;
      end else begin
         state_ff            <= state_in;
         send_window_size_ff <= send_window_size_in;
         rsp_valid_ff        <= rsp_valid_in;
         skid_valid_ff       <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid entry is only ever filled behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while result register empty");

   // An accepted event always leaves a result to deliver.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted event produced no result");

   // The window state moves only on an accepted event.
   assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(state_ff))
      else $error("state changed without an accepted event");

   // A loss never leaves the threshold below its floor.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.func == cwc_pkg::FUNC_FAST_RETRANSMIT ||
                   req_data.func == cwc_pkg::FUNC_TIMEOUT)
      |=> state_ff.threshold >= cwc_pkg::MIN_LOSS_THRESHOLD)
      else $error("loss threshold below minimum");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the congestion window controller. Events go in on
// the req channel, and every event returns exactly one result beat on rsp.
// A small tracker class keeps its own copy of the window, the slow-start
// threshold, the per-round-trip ack counter and the send window size. It
// predicts each result as the event beat is accepted and compares the
// predictions in order against the beats that leave the block.
module tb_top;
   import cwc_pkg::*;

   localparam int unsigned MAX_WINDOW = 256;
   localparam int unsigned EVENT_GOAL = 1100;

   // Tracks the sender's congestion state and queues the windows it should report.
   class window_tracker;
      logic [SIZE_W-1:0] window_size;
      logic [CWND_W-1:0] cwnd;
      logic [THR_W-1:0]  ssthresh;
      logic [CNT_W-1:0]  rtt_acks;
      rsp_type           expected_windows[$];
      int unsigned       mismatches;

      function new();
         window_size = RESET_SEND_WINDOW;
         cwnd        = RESET_CWND;
         ssthresh    = THR_W'(RESET_SEND_WINDOW);
         rtt_acks    = '0;
         mismatches  = 0;
      endfunction

      // The register can hold more than the block supports, so the size is clipped.
      function logic [SIZE_W-1:0] usable_size();
         return (window_size > MAX_WINDOW) ? SIZE_W'(MAX_WINDOW) : window_size;
      endfunction

      function logic [THR_W-1:0] loss_threshold(logic [FLIGHT_W-1:0] flight);
         logic [FLIGHT_W-1:0] clipped;
         clipped = (flight > usable_size()) ? usable_size() : flight;
         return ((clipped >> 1) > MIN_LOSS_THRESHOLD) ? THR_W'(clipped >> 1)
                                                      : MIN_LOSS_THRESHOLD;
      endfunction

      function void bump_window();
         if ((cwnd >> 1) < usable_size()) begin
            cwnd = cwnd + 1'b1;
         end
      endfunction

      function void note_event(req_type ev);
         rsp_type want;
         case (ev.func)
            FUNC_ACK: begin
               if (cwnd < ssthresh) begin
                  bump_window();
               end else begin
                  rtt_acks = rtt_acks + 1'b1;
                  if (rtt_acks >= cwnd) begin
                     bump_window();
                     rtt_acks = '0;
                  end
               end
            end
            FUNC_FAST_RETRANSMIT: begin
               ssthresh = loss_threshold(ev.flight_count);
               cwnd     = CWND_W'(ssthresh);
            end
            FUNC_TIMEOUT: begin
               ssthresh = loss_threshold(ev.flight_count);
               cwnd     = RESET_CWND;
            end
            default: begin
               cwnd     = RESET_CWND;
               ssthresh = THR_W'(usable_size());
               rtt_acks = '0;
            end
         endcase
         want.cwnd_out      = cwnd;
         want.threshold_out = ssthresh;
         want.slow_start    = (cwnd < ssthresh);
         expected_windows.push_back(want);
      endfunction

      function void check_window(rsp_type got);
         rsp_type want;
         if (expected_windows.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_windows.pop_front();
         if (got.cwnd_out !== want.cwnd_out) begin
            $display("%0t: cwnd_out expected %0d actual %0d",
                     $time, want.cwnd_out, got.cwnd_out);
            mismatches++;
         end
         if (got.threshold_out !== want.threshold_out) begin
            $display("%0t: threshold_out expected %0d actual %0d",
                     $time, want.threshold_out, got.threshold_out);
            mismatches++;
         end
         if (got.slow_start !== want.slow_start) begin
            $display("%0t: slow_start expected %b actual %b",
                     $time, want.slow_start, got.slow_start);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_wdata;

   // Percentage of cycles in which the sender idles and the receiver stalls.
   // It drops to zero for one whole random phase so that the block also sees
   // a long stretch at full rate in both directions.
   int unsigned       idle_pct = 31;
   int unsigned       events_sent = 0;
   window_tracker     tracker;

   congestion_window_controller #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver decides each cycle whether to hold off the next result beat.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Every result beat that leaves the block is checked against the oldest
   // prediction. Since all testbench inputs change through nonblocking
   // assignments, the values read here are the ones seen at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_window(rsp_data);
      end
   end

   // Offers one event beat after a random idle gap and holds it until the block
   // accepts it. The valid stays high on return so the next beat can follow
   // directly in the next cycle.
   task automatic send_event(input func_type kind, input logic [FLIGHT_W-1:0] flight);
      req_type ev;
      ev.func         = kind;
      ev.flight_count = flight;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      tracker.note_event(ev);
      events_sent++;
   endtask

   // Waits until every predicted result has come back. Each event yields a
   // result, so a short pause afterward is enough to leave the block idle.
   task automatic drain_windows();
      req_valid <= 1'b0;
      while (tracker.expected_windows.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // The size register is only rewritten while nothing is in flight.
   task automatic write_window_size(input logic [SIZE_W-1:0] value);
      drain_windows();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.window_size = value;
   endtask

   initial begin
      int unsigned       phase;
      int unsigned       phase_len;
      int unsigned       roll;
      int unsigned       span;
      logic [SIZE_W-1:0] size_pick;
      func_type          kind;
      logic [FLIGHT_W-1:0] flight;

      tracker   = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset size of 64. A fast retransmit with
      // the largest flight count saturates at the size. Acks in additive
      // increase build up the counter, and a second loss then shrinks the
      // window below it. The next ack must clear that stale counter and grow
      // the window. A small flight also checks the floor of two on the
      // threshold.
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_FAST_RETRANSMIT, FLIGHT_W'(511));
      send_event(FUNC_ACK, FLIGHT_W'(256));
      send_event(FUNC_ACK, FLIGHT_W'(1));
      send_event(FUNC_ACK, FLIGHT_W'(2));
      send_event(FUNC_FAST_RETRANSMIT, FLIGHT_W'(4));
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_TIMEOUT, FLIGHT_W'(6));
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_FAST_RETRANSMIT, FLIGHT_W'(5));
      send_event(FUNC_INIT, FLIGHT_W'(0));

      // A size of zero: the window can never grow, and initialize leaves a
      // threshold of zero.
      write_window_size(SIZE_W'(0));
      send_event(FUNC_INIT, FLIGHT_W'(511));
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_TIMEOUT, FLIGHT_W'(511));
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_FAST_RETRANSMIT, FLIGHT_W'(3));

      // A register value above the supported maximum acts as the maximum.
      write_window_size(SIZE_W'(511));
      send_event(FUNC_INIT, FLIGHT_W'(0));
      send_event(FUNC_ACK, FLIGHT_W'(511));
      send_event(FUNC_FAST_RETRANSMIT, FLIGHT_W'(511));

      // A size of one reaches the growth cap, a window of two, on the first ack.
      write_window_size(SIZE_W'(1));
      send_event(FUNC_INIT, FLIGHT_W'(0));
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_ACK, FLIGHT_W'(0));
      send_event(FUNC_ACK, FLIGHT_W'(0));

      // Random phases. Each one picks a size and opens with an initialize.
      // It then runs mostly acks, so the window gets through slow start and
      // additive increase up to its cap. Occasional losses and re-initializes
      // are mixed in. Small sizes dominate, because only they let the cap be
      // reached within a phase. Flight counts mostly stay near the size, with
      // full-range values mixed in.
      phase = 0;
      while (events_sent < EVENT_GOAL) begin
         case ($urandom_range(19))
            0: size_pick = SIZE_W'(0);
            1: size_pick = SIZE_W'(1);
            2: size_pick = SIZE_W'(256);
            3: size_pick = SIZE_W'(511);
            4: size_pick = SIZE_W'($urandom_range(511));
            5: size_pick = SIZE_W'($urandom_range(257, 511));
            default: size_pick = SIZE_W'($urandom_range(2, 12));
         endcase
         write_window_size(size_pick);
         idle_pct = (phase == 3) ? 0 : 31;
         phase_len = $urandom_range(60, 140);
         send_event(FUNC_INIT, FLIGHT_W'($urandom_range(511)));
         for (int unsigned i = 0; i < phase_len; i++) begin
            roll = $urandom_range(99);
            if (roll < 86) begin
               kind = FUNC_ACK;
            end else if (roll < 91) begin
               kind = FUNC_FAST_RETRANSMIT;
            end else if (roll < 97) begin
               kind = FUNC_TIMEOUT;
            end else begin
               kind = FUNC_INIT;
            end
            span = 2 * tracker.window_size + 3;
            if (span > 511) begin
               span = 511;
            end
            flight = ($urandom_range(3) == 0) ? FLIGHT_W'($urandom_range(511))
                                              : FLIGHT_W'($urandom_range(span));
            send_event(kind, flight);
         end
         phase++;
      end
      idle_pct = 31;

      // Let every result come back, then give a stray beat time to show up.
      drain_windows();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_windows.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: a correct run needs only a small fraction of this time.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
